// ===== rtl/sld_pkg.sv =====
// Shared constants and helpers for the sync word, length prefixed XOR deframer.
package sld_pkg;

	// Deframer phases.
	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_LEN     = 3'd1;
	localparam logic [2:0] PH_PAYLOAD = 3'd2;
	localparam logic [2:0] PH_CHECK   = 3'd3;

	// Result kinds.
	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_GOOD    = 2'd1;
	localparam logic [1:0] KIND_BADSUM  = 2'd2;
	localparam logic [1:0] KIND_TOOLONG = 2'd3;

	localparam logic [15:0] MAX_LENGTH_RESET = 16'd4087;
	localparam logic [7:0]  SYNC_FIRST       = 8'h51;

	typedef logic [7:0] byte_t;

	// Expected sync character for a given match position.
	function automatic byte_t sync_char(input logic [1:0] pos);
		byte_t c;
		case (pos)
			2'd0:    c = 8'h51;
			2'd1:    c = 8'h54;
			2'd2:    c = 8'h53;
			default: c = 8'h4F;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/sync_length_xor_deframer_unit.sv =====
// Sync word, length prefixed frame deframer with XOR checksum check.
// Usage: bytes of a received stream enter on the rx channel (rx_valid, rx_stall,
// rx_byte), one word per cycle. The block hunts for the sync characters Q T S O,
// then takes a little endian length of LENGTH_FIELD_BYTES bytes. Each payload
// byte leaves on the res channel as a kind 0 word; the byte after the payload is
// checked against the running XOR and a single status word (good, bad checksum)
// with last_flag set ends the frame. A declared length above max_length gives a
// too-long status at once, and hunting restarts with the following byte.
// Throughput: one byte per cycle while not stalled; the per-byte state update is
// one short pass between the input register and the result register. Reset:
// max_length returns to 4087, the deframer returns to hunting, and both
// registers are emptied. While res_stall holds a result, bytes that make no
// result keep moving; a byte that makes a result waits in the input register and
// rx_stall rises. max_length is written through cfg_we / cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce.
module sync_length_xor_deframer_unit #(
	parameter int LENGTH_FIELD_BYTES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 rx_valid,
	output logic                 rx_stall,
	input  sld_pkg::byte_t       rx_byte,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [1:0]           result_kind,
	output sld_pkg::byte_t       payload_byte,
	output logic [15:0]          frame_length,
	output logic                 last_flag
);
	import sld_pkg::*;

	localparam int AccW = 8 * LENGTH_FIELD_BYTES;
	localparam int CntW = (LENGTH_FIELD_BYTES > 1) ? $clog2(LENGTH_FIELD_BYTES) : 1;
	localparam logic [CntW-1:0] LastIdx = CntW'(LENGTH_FIELD_BYTES - 1);

	logic [15:0]     max_length_q;
	logic            valid_s1;
	byte_t           byte_s1;
	logic [2:0]      phase_q;
	logic [1:0]      sync_matched_q;
	logic [CntW-1:0] len_cnt_q;
	logic [AccW-1:0] len_acc_q;
	logic [15:0]     remaining_q;
	byte_t           xor_q;

	logic            res_valid_q;
	logic [1:0]      kind_q;
	byte_t           pbyte_q;
	logic [15:0]     flen_q;
	logic            last_q;

	logic [2:0]      phase_d;
	logic [1:0]      sync_matched_d;
	logic [CntW-1:0] len_cnt_d;
	logic [AccW-1:0] len_acc_d;
	logic [15:0]     remaining_d;
	byte_t           xor_d;
	logic            emit;
	logic [1:0]      kind_d;
	byte_t           pbyte_d;
	logic [15:0]     flen_d;
	logic [31:0]     acc_new32;
	logic [31:0]     acc_old32;
	logic            advance;
	logic            rx_accept;

	assign acc_old32 = 32'(len_acc_q);

	always_comb begin
		phase_d        = phase_q;
		sync_matched_d = sync_matched_q;
		len_cnt_d      = len_cnt_q;
		len_acc_d      = len_acc_q;
		remaining_d    = remaining_q;
		xor_d          = xor_q;
		emit           = 1'b0;
		kind_d         = KIND_DATA;
		pbyte_d        = '0;
		flen_d         = '0;
		for (int i = 0; i < LENGTH_FIELD_BYTES; i++) begin
			if (len_cnt_q == CntW'(i)) begin
				len_acc_d[8*i +: 8] = byte_s1;
			end
		end
		acc_new32 = 32'(len_acc_d);
		unique case (phase_q)
			PH_HUNT: begin
				len_acc_d = len_acc_q;
				if (byte_s1 == sync_char(sync_matched_q)) begin
					if (sync_matched_q == 2'd3) begin
						phase_d        = PH_LEN;
						sync_matched_d = 2'd0;
						len_cnt_d      = '0;
						len_acc_d      = '0;
						xor_d          = '0;
					end else begin
						sync_matched_d = sync_matched_q + 2'd1;
					end
				end else begin
					sync_matched_d = (byte_s1 == SYNC_FIRST) ? 2'd1 : 2'd0;
				end
			end
			PH_LEN: begin
				if (len_cnt_q != LastIdx) begin
					len_cnt_d = len_cnt_q + CntW'(1);
				end else begin
					len_cnt_d = '0;
					if (acc_new32 > {16'd0, max_length_q}) begin
						emit   = 1'b1;
						kind_d = KIND_TOOLONG;
						flen_d = (acc_new32 > 32'h0000_FFFF) ? 16'hFFFF : acc_new32[15:0];
						phase_d        = PH_HUNT;
						sync_matched_d = 2'd0;
						len_acc_d      = '0;
						remaining_d    = '0;
						xor_d          = '0;
					end else begin
						remaining_d = acc_new32[15:0];
						xor_d       = '0;
						phase_d     = (acc_new32[15:0] == 16'd0) ? PH_CHECK : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				len_acc_d   = len_acc_q;
				xor_d       = xor_q ^ byte_s1;
				remaining_d = remaining_q - 16'd1;
				if (remaining_q == 16'd1) begin
					phase_d = PH_CHECK;
				end
				emit    = 1'b1;
				kind_d  = KIND_DATA;
				pbyte_d = byte_s1;
			end
			PH_CHECK: begin
				emit           = 1'b1;
				kind_d         = (byte_s1 == xor_q) ? KIND_GOOD : KIND_BADSUM;
				flen_d         = acc_old32[15:0];
				phase_d        = PH_HUNT;
				sync_matched_d = 2'd0;
				len_cnt_d      = '0;
				len_acc_d      = '0;
				remaining_d    = '0;
				xor_d          = '0;
			end
			default: begin
				phase_d        = PH_HUNT;
				sync_matched_d = 2'd0;
				len_cnt_d      = '0;
				len_acc_d      = '0;
				remaining_d    = '0;
				xor_d          = '0;
			end
		endcase
	end

	// A word with no result may pass even while the output holds a stalled result.
	assign advance   = valid_s1 && (!emit || !res_valid_q || !res_stall);
	assign rx_stall  = valid_s1 && !advance;
	assign rx_accept = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q   <= MAX_LENGTH_RESET;
			valid_s1       <= 1'b0;
			phase_q        <= PH_HUNT;
			sync_matched_q <= 2'd0;
			len_cnt_q      <= '0;
			len_acc_q      <= '0;
			remaining_q    <= '0;
			xor_q          <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_length_q <= cfg_wdata;
			end
			if (rx_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q        <= phase_d;
				sync_matched_q <= sync_matched_d;
				len_cnt_q      <= len_cnt_d;
				len_acc_q      <= len_acc_d;
				remaining_q    <= remaining_d;
				xor_q          <= xor_d;
			end
			if (advance && emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_accept) begin
			byte_s1 <= rx_byte;
		end
		if (advance && emit) begin
			kind_q  <= kind_d;
			pbyte_q <= pbyte_d;
			flen_q  <= flen_d;
			last_q  <= (kind_d != KIND_DATA);
		end
	end

	assign res_valid    = res_valid_q;
	assign result_kind  = kind_q;
	assign payload_byte = pbyte_q;
	assign frame_length = flen_q;
	assign last_flag    = last_q;

`ifndef SYNTHESIS
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1)
		else $error("rx_stall raised with an empty input register");

	a_data_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && result_kind == KIND_DATA) |-> (!last_flag && frame_length == 16'd0))
		else $error("payload word carries status fields");

	a_status_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && result_kind != KIND_DATA) |-> (last_flag && payload_byte == 8'd0))
		else $error("status word malformed");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(result_kind)
			&& $stable(payload_byte) && $stable(frame_length)))
		else $error("stalled result changed");
`endif

endmodule
